// ===== hw/rtl/svd4_pkg.sv =====
// ----------------------------------------------------------------------------
// svd4_pkg
// Shared types and constants of the 4D surface voxel detector.
// ----------------------------------------------------------------------------
`default_nettype none

package svd4_pkg;

    // Configuration port layout.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_T = 2'd3;

    // Request kinds on the input channel.
    localparam logic FUNC_VOXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Data that travels down the chain of window cells.
    typedef struct packed {
        logic near_bg;  // some voxel in the partial window is background
        logic center;   // the centre voxel is foreground with a nonzero label
    } t_vox;

endpackage

`default_nettype wire

// ===== hw/rtl/svd4_stage.sv =====
// ----------------------------------------------------------------------------
// svd4_stage
// One window cell: ORs the background flag over three neighbors spaced one
// stride apart along one axis, using two circular delay lines of that stride.
// ----------------------------------------------------------------------------
`default_nettype none

module svd4_stage
    import svd4_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int MAXD  = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_restart,
    input  wire                          i_step,
    input  wire [$clog2(DEPTH+1)-1:0]    i_stride,
    input  wire [$clog2(MAXD+1)-1:0]     i_size,
    input  t_vox                         i_in,
    input  wire                          i_in_valid,
    output t_vox                         o_out,
    output logic                         o_out_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = $clog2(DEPTH + 1);
    localparam int DW = $clog2(MAXD + 1);
    localparam int CW = $clog2(MAXD);

    t_vox                 r_mem1 [DEPTH];
    logic                 r_mem2 [DEPTH];
    t_vox                 r_rd1;
    logic                 r_rd2;
    logic [AW-1:0]        r_ptr;
    logic                 r_full;
    logic [CW-1:0]        r_coord;

    logic [AW-1:0]        n_ptr;
    logic                 w_en;
    logic                 w_wrap;
    logic                 w_one;
    logic                 w_lo_ok;
    logic                 w_hi_ok;

    assign w_en    = i_step && i_in_valid;
    assign w_wrap  = (SW'(r_ptr) == i_stride - SW'(1));
    assign n_ptr   = w_wrap ? '0 : r_ptr + AW'(1);
    assign w_one   = (i_stride == SW'(1));
    assign w_lo_ok = (r_coord != '0);
    assign w_hi_ok = (DW'(r_coord) != i_size - DW'(1));

    // Delay lines: write at the pointer, prefetch the next slot.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem1[r_ptr] <= i_in;
            r_mem2[r_ptr] <= r_rd1.near_bg;
            r_rd1         <= w_one ? i_in : r_mem1[n_ptr];
            r_rd2         <= w_one ? r_rd1.near_bg : r_mem2[n_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_ptr   <= '0;
            r_full  <= 1'b0;
            r_coord <= '0;
        end else if (w_en) begin
            r_ptr <= n_ptr;
            if (w_wrap) begin
                r_full <= 1'b1;
            end
            if (r_full && w_wrap) begin
                r_coord <= w_hi_ok ? r_coord + CW'(1) : '0;
            end
        end
    end

    assign o_out_valid    = i_in_valid && r_full;
    assign o_out.near_bg  = (i_in.near_bg && w_hi_ok) || r_rd1.near_bg || (r_rd2 && w_lo_ok);
    assign o_out.center   = r_rd1.center;

endmodule

`default_nettype wire

// ===== hw/rtl/surface_voxel_detect_4d_top.sv =====
// ----------------------------------------------------------------------------
// surface_voxel_detect_4d_top
// Marks labelled foreground voxels of a raster-ordered 4D volume that touch
// background anywhere in their 3x3x3x3 neighborhood.
// ----------------------------------------------------------------------------
// The block takes one voxel request per clock cycle while the output is free
// and, once the window has filled, returns one result per accepted voxel,
// delayed by the window reach of size_x*size_y*size_z + size_x*size_y +
// size_x + 1 voxels. The window is a chain of four cells, one per axis, each
// holding two circular delay lines whose length is the axis stride; every
// memory sees one write and one read per cycle, which sets the rate. After
// the final voxel of a sequence has been received, every further request
// (voxel or drain) earns exactly one result; the chain is then pushed
// internally with padding voxels, one per cycle while the output is free.
// When the sequence is shorter than the window reach, the first such result
// waits while the chain fills, and the input is held off meanwhile. A
// configuration write restarts the stream; input waits while strides settle.
// ----------------------------------------------------------------------------
`default_nettype none

module surface_voxel_detect_4d_top
    import svd4_pkg::*;
#(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 16,
    parameter int MAX_T = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire                     i_func,
    input  wire                     i_foreground,
    input  wire                     i_label_nonzero,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output logic                    o_surface_flag,
    output logic                    o_last_voxel,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int W_SX  = $clog2(MAX_X + 1);
    localparam int W_SY  = $clog2(MAX_Y + 1);
    localparam int W_SZ  = $clog2(MAX_Z + 1);
    localparam int W_ST  = $clog2(MAX_T + 1);
    localparam int W_CX  = $clog2(MAX_X);
    localparam int W_CY  = $clog2(MAX_Y);
    localparam int W_CZ  = $clog2(MAX_Z);
    localparam int W_CT  = $clog2(MAX_T);
    localparam int W_XY  = $clog2(MAX_X * MAX_Y + 1);
    localparam int W_XYZ = $clog2(MAX_X * MAX_Y * MAX_Z + 1);

    // Register values are clamped into 1..max on write.
    function automatic int clamp_size(input int v, input int maxv);
        if (v == 0) begin
            return 1;
        end else if (v > maxv) begin
            return maxv;
        end
        return v;
    endfunction

    logic [W_SX-1:0]   r_sx;
    logic [W_SY-1:0]   r_sy;
    logic [W_SZ-1:0]   r_sz;
    logic [W_ST-1:0]   r_st;
    logic [W_XY-1:0]   r_sxy;
    logic [W_XYZ-1:0]  r_sxyz;
    logic [1:0]        r_settle;

    logic [W_CX-1:0]   r_in_x, r_out_x;
    logic [W_CY-1:0]   r_in_y, r_out_y;
    logic [W_CZ-1:0]   r_in_z, r_out_z;
    logic [W_CT-1:0]   r_in_t, r_out_t;
    logic              r_recv;
    logic              r_owed;
    logic              r_out_valid;
    logic              r_surface;
    logic              r_last;

    logic              w_cfg_acc;
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_voxel_push;
    logic              w_flush_push;
    logic              w_push;
    logic              w_emit;
    logic              w_in_last;
    logic              w_out_last;
    logic              w_completing;
    logic              w_restart;

    t_vox              w_x_in, w_x_out, w_y_out, w_z_out, w_t_out;
    logic              w_x_v, w_y_v, w_z_v, w_t_v;

    // ------------------------------------------------------------------
    // Handshake and control decisions
    // ------------------------------------------------------------------
    assign o_cfg_ready  = 1'b1;
    assign w_cfg_acc    = i_cfg_valid && o_cfg_ready;
    assign w_out_free   = !r_out_valid || i_out_ready;

    assign w_in_last  = (W_SX'(r_in_x) == r_sx - W_SX'(1)) && (W_SY'(r_in_y) == r_sy - W_SY'(1))
                     && (W_SZ'(r_in_z) == r_sz - W_SZ'(1)) && (W_ST'(r_in_t) == r_st - W_ST'(1));
    assign w_out_last = (W_SX'(r_out_x) == r_sx - W_SX'(1)) && (W_SY'(r_out_y) == r_sy - W_SY'(1))
                     && (W_SZ'(r_out_z) == r_sz - W_SZ'(1)) && (W_ST'(r_out_t) == r_st - W_ST'(1));

    // Padding pushes run only when a result is owed to an earlier request.
    assign w_flush_push = r_recv && r_owed && w_out_free && (r_settle == 2'd0);

    // Before the sequence end, a voxel may produce a result, so the output
    // register must be free. After it, one owed result at most is allowed.
    always_comb begin
        if (r_settle != 2'd0) begin
            o_in_ready = 1'b0;
        end else if (r_recv) begin
            o_in_ready = !r_owed || (w_flush_push && w_t_v && !w_out_last);
        end else begin
            o_in_ready = w_out_free;
        end
    end

    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_voxel_push = w_in_acc && (i_func == FUNC_VOXEL) && !r_recv;
    assign w_push       = w_voxel_push || w_flush_push;
    assign w_emit       = w_push && w_t_v;
    assign w_completing = w_voxel_push && w_in_last;
    assign w_restart    = w_cfg_acc || (w_emit && w_out_last);

    // ------------------------------------------------------------------
    // Chain of window cells, x first
    // ------------------------------------------------------------------
    assign w_x_in.near_bg = w_voxel_push && !i_foreground;
    assign w_x_in.center  = w_voxel_push && i_foreground && i_label_nonzero;

    svd4_stage #(.DEPTH(1), .MAXD(MAX_X)) u_stage_x (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (w_restart),
        .i_step      (w_push),
        .i_stride    (1'b1),
        .i_size      (r_sx),
        .i_in        (w_x_in),
        .i_in_valid  (1'b1),
        .o_out       (w_x_out),
        .o_out_valid (w_x_v)
    );

    svd4_stage #(.DEPTH(MAX_X), .MAXD(MAX_Y)) u_stage_y (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (w_restart),
        .i_step      (w_push),
        .i_stride    (r_sx),
        .i_size      (r_sy),
        .i_in        (w_x_out),
        .i_in_valid  (w_x_v),
        .o_out       (w_y_out),
        .o_out_valid (w_y_v)
    );

    svd4_stage #(.DEPTH(MAX_X * MAX_Y), .MAXD(MAX_Z)) u_stage_z (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (w_restart),
        .i_step      (w_push),
        .i_stride    (r_sxy),
        .i_size      (r_sz),
        .i_in        (w_y_out),
        .i_in_valid  (w_y_v),
        .o_out       (w_z_out),
        .o_out_valid (w_z_v)
    );

    svd4_stage #(.DEPTH(MAX_X * MAX_Y * MAX_Z), .MAXD(MAX_T)) u_stage_t (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (w_restart),
        .i_step      (w_push),
        .i_stride    (r_sxyz),
        .i_size      (r_st),
        .i_in        (w_z_out),
        .i_in_valid  (w_z_v),
        .o_out       (w_t_out),
        .o_out_valid (w_t_v)
    );

    // ------------------------------------------------------------------
    // Configuration and stride products
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_sxy  <= W_XY'(r_sx * r_sy);
        r_sxyz <= W_XYZ'(r_sxy * r_sz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx     <= W_SX'(clamp_size(64, MAX_X));
            r_sy     <= W_SY'(clamp_size(64, MAX_Y));
            r_sz     <= W_SZ'(clamp_size(16, MAX_Z));
            r_st     <= W_ST'(clamp_size(32, MAX_T));
            r_settle <= 2'd2;
        end else if (w_cfg_acc) begin
            r_settle <= 2'd2;
            unique case (i_cfg_index)
                CFG_SIZE_X: r_sx <= W_SX'(clamp_size(int'(i_cfg_data[6:0]), MAX_X));
                CFG_SIZE_Y: r_sy <= W_SY'(clamp_size(int'(i_cfg_data[6:0]), MAX_Y));
                CFG_SIZE_Z: r_sz <= W_SZ'(clamp_size(int'(i_cfg_data[4:0]), MAX_Z));
                CFG_SIZE_T: r_st <= W_ST'(clamp_size(int'(i_cfg_data[5:0]), MAX_T));
                default: begin
                end
            endcase
        end else if (r_settle != 2'd0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    // ------------------------------------------------------------------
    // Stream position, owed results and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_in_x  <= '0;
            r_in_y  <= '0;
            r_in_z  <= '0;
            r_in_t  <= '0;
            r_out_x <= '0;
            r_out_y <= '0;
            r_out_z <= '0;
            r_out_t <= '0;
            r_recv  <= 1'b0;
            r_owed  <= 1'b0;
        end else begin
            if (w_voxel_push) begin
                if (W_SX'(r_in_x) != r_sx - W_SX'(1)) begin
                    r_in_x <= r_in_x + W_CX'(1);
                end else begin
                    r_in_x <= '0;
                    if (W_SY'(r_in_y) != r_sy - W_SY'(1)) begin
                        r_in_y <= r_in_y + W_CY'(1);
                    end else begin
                        r_in_y <= '0;
                        if (W_SZ'(r_in_z) != r_sz - W_SZ'(1)) begin
                            r_in_z <= r_in_z + W_CZ'(1);
                        end else begin
                            r_in_z <= '0;
                            if (W_ST'(r_in_t) != r_st - W_ST'(1)) begin
                                r_in_t <= r_in_t + W_CT'(1);
                            end else begin
                                r_in_t <= '0;
                            end
                        end
                    end
                end
            end
            if (w_completing) begin
                r_recv <= 1'b1;
            end
            if (w_emit) begin
                if (W_SX'(r_out_x) != r_sx - W_SX'(1)) begin
                    r_out_x <= r_out_x + W_CX'(1);
                end else begin
                    r_out_x <= '0;
                    if (W_SY'(r_out_y) != r_sy - W_SY'(1)) begin
                        r_out_y <= r_out_y + W_CY'(1);
                    end else begin
                        r_out_y <= '0;
                        if (W_SZ'(r_out_z) != r_sz - W_SZ'(1)) begin
                            r_out_z <= r_out_z + W_CZ'(1);
                        end else begin
                            r_out_z <= '0;
                            r_out_t <= r_out_t + W_CT'(1);
                        end
                    end
                end
            end
            // A request after the sequence end owes a result; so does the
            // final voxel when the window has not yet produced one for it.
            if ((w_in_acc && r_recv) || (w_completing && !w_emit)) begin
                r_owed <= 1'b1;
            end else if (w_flush_push && w_t_v) begin
                r_owed <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_surface <= w_t_out.center && w_t_out.near_bg;
            r_last    <= w_out_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_surface_flag = r_surface;
    assign o_last_voxel   = r_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_out_free)
        else $error("result produced while output register is occupied");

    a_owed_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_owed |-> r_recv)
        else $error("result owed before the sequence end");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_out_last) |=> (!r_recv && !r_owed))
        else $error("stream did not restart after the final result");

    a_single_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_voxel_push && w_flush_push))
        else $error("voxel push and padding push in the same cycle");

endmodule

`default_nettype wire

// ===== verif/tb_surface_voxel_detect_4d_top.sv =====
// ----------------------------------------------------------------------------
// tb_surface_voxel_detect_4d_top
// Self-checking testbench for the 4D surface voxel detector.
// ----------------------------------------------------------------------------
// Voxel and drain requests are streamed into the block through a queue-fed
// driver, while an independent surface predictor models the raster window
// and the result order. A monitor compares every returned result with the
// oldest predicted one. Volume sizes are changed between phases, only while
// the block is idle. The phases cover directed corner cases, each axis at
// its maximum and many small random volumes. Both sides of the stream stall
// in random bursts, except late in the final phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_surface_voxel_detect_4d_top;
    import svd4_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_X = 64;
    localparam int MAX_Y = 64;
    localparam int MAX_Z = 16;
    localparam int MAX_T = 32;
    // The circular voxel store spans two window reaches plus one entry.
    localparam int VOX_DEPTH = 2 * (MAX_X * MAX_Y * MAX_Z + MAX_X * MAX_Y + MAX_X + 1) + 1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 1600;

    typedef struct packed {
        logic func;
        logic fg;
        logic lab;
    } voxel_req_t;

    typedef struct packed {
        logic surface;
        logic last;
    } surface_res_t;

    // ------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero.
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_func = FUNC_VOXEL;
    logic                  i_foreground = 1'b0;
    logic                  i_label_nonzero = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_surface_flag;
    logic                  o_last_voxel;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_SIZE_X;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    always #4 i_clk = ~i_clk;

    surface_voxel_detect_4d_top #(
        .MAX_X(MAX_X),
        .MAX_Y(MAX_Y),
        .MAX_Z(MAX_Z),
        .MAX_T(MAX_T)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_foreground    (i_foreground),
        .i_label_nonzero (i_label_nonzero),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_surface_flag  (o_surface_flag),
        .o_last_voxel    (o_last_voxel),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Surface predictor state: its own copy of the sizes, the voxel store,
    // the raster positions of the next input and the next result voxel.
    // ------------------------------------------------------------------
    bit [1:0]    vox_mem [VOX_DEPTH];
    int unsigned dim_x, dim_y, dim_z, dim_t;
    int unsigned in_px, in_py, in_pz, in_pt;
    int unsigned out_px, out_py, out_pz, out_pt;
    int unsigned rd_ptr;
    int unsigned backlog;
    bit          volume_done;

    surface_res_t surface_q[$];
    voxel_req_t   request_q[$];

    int  mismatches = 0;
    int  cycles = 0;
    bit  calm = 1'b0;      // no stalls on either side
    bit  in_taken = 1'b0;  // input request accepted at the last rising edge
    int  send_gap = 0;
    int  sink_gap = 0;
    int  made_items = 0;

    // A register value is masked to its width, then clamped into 1..max.
    function automatic int unsigned size_for(logic [CFG_IDX_W-1:0] idx,
                                             logic [CFG_DATA_W-1:0] data);
        int unsigned v;
        int unsigned lim;
        case (idx)
            CFG_SIZE_X: begin v = data & 7'h7F; lim = MAX_X; end
            CFG_SIZE_Y: begin v = data & 7'h7F; lim = MAX_Y; end
            CFG_SIZE_Z: begin v = data & 7'h1F; lim = MAX_Z; end
            default:    begin v = data & 7'h3F; lim = MAX_T; end
        endcase
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic void restart_volume();
        in_px = 0; in_py = 0; in_pz = 0; in_pt = 0;
        out_px = 0; out_py = 0; out_pz = 0; out_pt = 0;
        rd_ptr = 0;
        backlog = 0;
        volume_done = 1'b0;
    endfunction

    // Steps a raster position; returns 1 when it wraps past the last voxel.
    function automatic bit step_raster(ref int unsigned x, ref int unsigned y,
                                       ref int unsigned z, ref int unsigned t);
        x++;
        if (x < dim_x) return 1'b0;
        x = 0; y++;
        if (y < dim_y) return 1'b0;
        y = 0; z++;
        if (z < dim_z) return 1'b0;
        z = 0; t++;
        if (t < dim_t) return 1'b0;
        t = 0;
        return 1'b1;
    endfunction

    // The voxel at the read pointer is surface when it is labelled foreground
    // and some in-volume neighbor of the 3x3x3x3 window is background.
    function automatic bit touches_background();
        int sx, sy, sz, st, sxy, sxyz;
        int nx, ny, nz, nt;
        longint addr;
        sx = dim_x; sy = dim_y; sz = dim_z; st = dim_t;
        sxy = sx * sy;
        sxyz = sxy * sz;
        if (vox_mem[rd_ptr] != 2'b11) return 1'b0;
        for (int dt = -1; dt <= 1; dt++)
            for (int dz = -1; dz <= 1; dz++)
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++) begin
                        nx = int'(out_px) + dx;
                        ny = int'(out_py) + dy;
                        nz = int'(out_pz) + dz;
                        nt = int'(out_pt) + dt;
                        if (dx == 0 && dy == 0 && dz == 0 && dt == 0) continue;
                        // Neighbors outside the volume count as foreground.
                        if (nx < 0 || nx >= sx || ny < 0 || ny >= sy ||
                            nz < 0 || nz >= sz || nt < 0 || nt >= st) continue;
                        addr = longint'(rd_ptr) + dx + longint'(dy) * sx +
                               longint'(dz) * sxy + longint'(dt) * sxyz;
                        if (addr < 0) addr += VOX_DEPTH;
                        if (addr >= VOX_DEPTH) addr -= VOX_DEPTH;
                        if (vox_mem[addr][0] == 1'b0) return 1'b1;
                    end
        return 1'b0;
    endfunction

    // One accepted request: store the voxel, then release a result once the
    // window ahead of it is complete or the whole volume has arrived.
    function automatic void predict_surface(voxel_req_t req);
        int unsigned reach;
        int unsigned wr;
        surface_res_t res;
        reach = dim_x * dim_y * dim_z + dim_x * dim_y + dim_x + 1;
        if (req.func == FUNC_VOXEL && !volume_done) begin
            wr = rd_ptr + backlog;
            if (wr >= VOX_DEPTH) wr -= VOX_DEPTH;
            vox_mem[wr] = {req.lab, req.fg};
            backlog++;
            if (step_raster(in_px, in_py, in_pz, in_pt)) volume_done = 1'b1;
        end
        if (backlog == 0) return;
        if (!volume_done && backlog < reach + 1) return;
        res.surface = touches_background();
        res.last = (out_px == dim_x - 1 && out_py == dim_y - 1 &&
                    out_pz == dim_z - 1 && out_pt == dim_t - 1);
        surface_q.push_back(res);
        if (res.last) begin
            restart_volume();
        end else begin
            void'(step_raster(out_px, out_py, out_pz, out_pt));
            rd_ptr++;
            if (rd_ptr >= VOX_DEPTH) rd_ptr = 0;
            backlog--;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, feed accepted requests and register
    // writes to the predictor and check every accepted result in order.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        surface_res_t exp_res;
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SIZE_X: dim_x = size_for(i_cfg_index, i_cfg_data);
                CFG_SIZE_Y: dim_y = size_for(i_cfg_index, i_cfg_data);
                CFG_SIZE_Z: dim_z = size_for(i_cfg_index, i_cfg_data);
                default:    dim_t = size_for(i_cfg_index, i_cfg_data);
            endcase
            restart_volume();
        end
        if (in_taken) begin
            predict_surface('{func: i_func, fg: i_foreground, lab: i_label_nonzero});
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (surface_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: surface=%0b last=%0b",
                             o_surface_flag, o_last_voxel);
                end
            end else begin
                exp_res = surface_q.pop_front();
                if (o_surface_flag !== exp_res.surface || o_last_voxel !== exp_res.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: expected surface=%0b last=%0b, got %0b %0b",
                                 exp_res.surface, exp_res.last, o_surface_flag, o_last_voxel);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver: at each falling edge, present the next queued request
    // once the previous one has gone, with random idle bursts in between.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        voxel_req_t req;
        if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
                req = request_q.pop_front();
                i_func <= req.func;
                i_foreground <= req.fg;
                i_label_nonzero <= req.lab;
                i_in_valid <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 12);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result sink: ready drops in random bursts while stalls are allowed.
    always @(negedge i_clk) begin
        if (sink_gap > 0) begin
            sink_gap--;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
            sink_gap = $urandom_range(0, 11);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until the sender is empty and every predicted result has come,
    // then leave room for work that produces no result.
    task automatic wait_drained();
        while (request_q.size() != 0 || i_in_valid || surface_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic push_req(logic func, logic fg, logic lab);
        request_q.push_back('{func: func, fg: fg, lab: lab});
        made_items++;
    endtask

    function automatic void push_random_voxel();
        // Mostly labelled foreground so that the neighbor search matters.
        request_q.push_back('{func: FUNC_VOXEL,
                              fg: ($urandom_range(0, 7) != 0),
                              lab: ($urandom_range(0, 3) != 0)});
        made_items++;
    endfunction

    // One phase: set all four sizes, send whole volumes with stray drains,
    // then enough requests to flush each tail, optionally a broken volume.
    task automatic run_volumes(logic [CFG_DATA_W-1:0] rx, logic [CFG_DATA_W-1:0] ry,
                               logic [CFG_DATA_W-1:0] rz, logic [CFG_DATA_W-1:0] rt,
                               int count, bit broken);
        int unsigned voxels;
        write_size(CFG_SIZE_X, rx);
        write_size(CFG_SIZE_Y, ry);
        write_size(CFG_SIZE_Z, rz);
        write_size(CFG_SIZE_T, rt);
        voxels = size_for(CFG_SIZE_X, rx) * size_for(CFG_SIZE_Y, ry) *
                 size_for(CFG_SIZE_Z, rz) * size_for(CFG_SIZE_T, rt);
        for (int s = 0; s < count; s++) begin
            for (int v = 0; v < voxels; v++) begin
                if ($urandom_range(0, 9) == 0) push_req(FUNC_DRAIN, $urandom, $urandom);
                push_random_voxel();
            end
            // After the volume, voxel requests act as drains too.
            for (int v = 0; v < voxels; v++) begin
                if ($urandom_range(0, 1) == 0) push_req(FUNC_DRAIN, $urandom, $urandom);
                else push_random_voxel();
            end
        end
        if (broken) begin
            for (int v = $urandom_range(1, voxels); v > 0; v--) push_random_voxel();
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        dim_x = MAX_X; dim_y = MAX_Y; dim_z = MAX_Z; dim_t = MAX_T;
        restart_volume();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single-voxel volumes: zero sizes clamp to one, and a drain with
        // nothing pending gives nothing. Every voxel is its own volume.
        write_size(CFG_SIZE_X, 7'd0);
        write_size(CFG_SIZE_Y, 7'd0);
        write_size(CFG_SIZE_Z, 7'd0);
        write_size(CFG_SIZE_T, 7'd0);
        push_req(FUNC_DRAIN, 1'b1, 1'b1);
        push_req(FUNC_VOXEL, 1'b1, 1'b1);
        push_req(FUNC_VOXEL, 1'b0, 1'b1);
        push_req(FUNC_VOXEL, 1'b1, 1'b0);
        push_req(FUNC_VOXEL, 1'b0, 1'b0);
        push_req(FUNC_DRAIN, 1'b0, 1'b0);
        wait_drained();

        // A 2x2 plane with one background voxel: the labelled foreground voxels become surface.
        // The drain before the tail gives nothing, and voxels after the end
        // of the volume only flush it.
        write_size(CFG_SIZE_X, 7'd2);
        write_size(CFG_SIZE_Y, 7'd2);
        write_size(CFG_SIZE_Z, 7'd1);
        write_size(CFG_SIZE_T, 7'd1);
        push_req(FUNC_VOXEL, 1'b1, 1'b1);
        push_req(FUNC_DRAIN, 1'b1, 1'b1);
        push_req(FUNC_VOXEL, 1'b0, 1'b1);
        push_req(FUNC_VOXEL, 1'b1, 1'b1);
        push_req(FUNC_VOXEL, 1'b1, 1'b0);
        push_req(FUNC_VOXEL, 1'b1, 1'b1);
        push_req(FUNC_DRAIN, 1'b0, 1'b0);
        push_req(FUNC_VOXEL, 1'b0, 1'b0);
        push_req(FUNC_DRAIN, 1'b1, 1'b0);
        wait_drained();

        // Each axis at its maximum, reached through over-range writes, then a mixed volume.
        run_volumes(7'd127, 7'd1, 7'd1, 7'd1, 1, 1'b0);
        run_volumes(7'd1, 7'd100, 7'd1, 7'd1, 1, 1'b0);
        run_volumes(7'd1, 7'd1, 7'd127, 7'd1, 1, 1'b0);
        run_volumes(7'd1, 7'd1, 7'd1, 7'd127, 1, 1'b0);
        run_volumes(7'd3, 7'd2, 7'd16, 7'd2, 1, 1'b0);

        // Small random volumes; some are cut short by the next size change.
        made_items = 0;
        while (made_items < RANDOM_ITEMS) begin
            if (made_items > RANDOM_ITEMS * 4 / 5) calm = 1'b1;
            run_volumes($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(1, 4),
                        $urandom_range(1, 4), $urandom_range(1, 3),
                        ($urandom_range(0, 3) == 0));
        end

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
